### hdl/ball_beam_cascade_controller_top_defines.svh
// Assertion macros for the ball-and-beam cascade controller checker.
// No dependencies; included by bbcc_checker.sv.
`ifndef BALL_BEAM_CASCADE_CONTROLLER_TOP_DEFINES_SVH
`define BALL_BEAM_CASCADE_CONTROLLER_TOP_DEFINES_SVH

// Clocked property, masked while reset is asserted.
`define BBCC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property that must also hold during reset.
`define BBCC_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/bbcc_pkg.sv
// Shared widths, fixed-point constants and rounding helpers for the
// ball-and-beam cascade controller. No dependencies.
package bbcc_pkg;

    localparam int VOLT_W  = 18;
    localparam int TGT_W   = 18;
    localparam int KP_W    = 11;
    localparam int DAC_W   = 24;
    localparam int ANG_W   = 17;
    localparam int ERR_W   = 19;
    localparam int ACC_W   = 36;
    localparam int XNUM_W  = 28;
    localparam int MUL_A_W = 29;
    localparam int MUL_B_W = 33;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int WIDE_W  = 46;
    localparam int DIV_SHIFT = 35;

    typedef logic signed [MUL_A_W-1:0] mul_a_t;
    typedef logic signed [MUL_B_W-1:0] mul_b_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [WIDE_W-1:0]  wide_t;

    // Multiplier coefficients (Q16.16)
    localparam mul_b_t C_POS_GAIN    = 33'sd8826;
    localparam mul_b_t C_FILT_IN     = 33'sd20578;
    localparam mul_b_t C_FILT_FB     = 33'sd44958;
    localparam mul_b_t C_ANG_GAIN    = -33'sd39702;
    // ceil(2^35 / 10): exact floor division by ten for any 32-bit numerator
    localparam mul_b_t C_DIV10_RECIP = 33'sd3435973837;

    // Adders and limits (Q16.16)
    localparam wide_t C_POS_OFFS  = 46'sd14562;
    localparam wide_t C_ANG_OFFS  = 46'sd71460;
    localparam wide_t C_NEG_BIAS  = 46'sd11436;
    localparam wide_t C_POS_BIAS  = 46'sd1147;
    localparam wide_t C_LIMIT     = 46'sd49807;
    localparam wide_t C_DRIVE_MAX = 46'sd327680;
    localparam wide_t C_ROUND_ADD = 46'sd5;

    // Drop 16 fraction bits, round to nearest with ties toward +infinity.
    function automatic wide_t q_round(input prod_t p);
        prod_t s;
        s = p + prod_t'(32768);
        return s[WIDE_W+15:16];
    endfunction

    function automatic wide_t clamp(input wide_t v, input wide_t lim);
        wide_t r;
        r = v;
        if (v < -lim)
            r = -lim;
        else if (v > lim)
            r = lim;
        return r;
    endfunction

endpackage

### hdl/ball_beam_cascade_controller_top.sv
// Ball-and-beam cascade controller: sequencer around one shared multiplier.
// Depends on bbcc_pkg.
//
//  channel   | handshake            | payload
//  ----------+----------------------+-----------------------------------------
//  input     | in_valid / in_ready  | position_volts, angle_volts,
//            |                      | target_position
//  output    | out_valid / out_ready| dac_code, angle_target
//  config    | cfg_we               | cfg_wdata (kp_angle, 11-bit signed)
//
// From acceptance to a valid result, each request makes six passes through
// the shared multiplier (one product per cycle, registered) plus the angle
// error, drive and result states. The sequencer is back in idle when the
// result appears, so a request is taken only once the last one is through,
// also while the last result still waits in the output register. The final
// step stalls only when that register is still full. Reset clears the gain,
// the filter state and the sequencer.
module ball_beam_cascade_controller_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic signed [bbcc_pkg::KP_W-1:0]     cfg_wdata,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic        [bbcc_pkg::VOLT_W-1:0]   position_volts,
    input  logic        [bbcc_pkg::VOLT_W-1:0]   angle_volts,
    input  logic signed [bbcc_pkg::TGT_W-1:0]    target_position,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic        [bbcc_pkg::DAC_W-1:0]    dac_code,
    output logic signed [bbcc_pkg::ANG_W-1:0]    angle_target
);
    import bbcc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL_POS,   // pv * position gain
        S_FILT_A,    // form position error; prior error * filter input gain
        S_FILT_B,    // hold first filter term; filter output * feedback gain
        S_ANG,       // close the filter; av * angle gain
        S_AERR,      // angle error, bias and clamp
        S_KP,        // error * kp
        S_DRIVE,     // clamp drive, build the DAC numerator
        S_DIV,       // numerator * reciprocal of ten
        S_DONE       // present the result
    } state_t;

    state_t state_reg, state_next;

    logic signed [KP_W-1:0]   kp_reg, kp_next;
    logic        [VOLT_W-1:0] pv_reg, pv_next;
    logic        [VOLT_W-1:0] av_reg, av_next;
    logic signed [TGT_W-1:0]  tgt_reg, tgt_next;
    logic signed [ERR_W-1:0]  err_reg, err_next;
    logic signed [ERR_W-1:0]  prior_reg, prior_next;
    logic signed [ANG_W-1:0]  filt_reg, filt_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic signed [ANG_W-1:0]  aerr_reg, aerr_next;
    logic        [XNUM_W-1:0] x_reg, x_next;
    prod_t                    prod_reg, prod_next;
    logic                     out_valid_reg, out_valid_next;
    logic        [DAC_W-1:0]  dac_reg, dac_next;
    logic signed [ANG_W-1:0]  ang_out_reg, ang_out_next;

    mul_a_t mul_a;
    mul_b_t mul_b;
    wide_t  w_tmp;
    wide_t  w_err;
    wide_t  w_y;

    always_comb
    begin
        state_next     = state_reg;
        kp_next        = kp_reg;
        pv_next        = pv_reg;
        av_next        = av_reg;
        tgt_next       = tgt_reg;
        err_next       = err_reg;
        prior_next     = prior_reg;
        filt_next      = filt_reg;
        acc_next       = acc_reg;
        aerr_next      = aerr_reg;
        x_next         = x_reg;
        out_valid_next = out_valid_reg;
        dac_next       = dac_reg;
        ang_out_next   = ang_out_reg;
        mul_a          = '0;
        mul_b          = '0;
        w_tmp          = '0;
        w_err          = '0;
        w_y            = '0;

        if (cfg_we)
            kp_next = cfg_wdata;

        // drop the result once the consumer takes it
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    pv_next    = position_volts;
                    av_next    = angle_volts;
                    tgt_next   = target_position;
                    state_next = S_MUL_POS;
                end
            end
            S_MUL_POS:
            begin
                mul_a      = mul_a_t'({1'b0, pv_reg});
                mul_b      = C_POS_GAIN;
                state_next = S_FILT_A;
            end
            S_FILT_A:
            begin
                w_tmp      = q_round(prod_reg) - C_POS_OFFS;
                w_err      = WIDE_W'(tgt_reg) - w_tmp;
                err_next   = w_err[ERR_W-1:0];
                mul_a      = MUL_A_W'(prior_reg);
                mul_b      = C_FILT_IN;
                state_next = S_FILT_B;
            end
            S_FILT_B:
            begin
                acc_next   = prod_reg[ACC_W-1:0];
                mul_a      = MUL_A_W'(filt_reg);
                mul_b      = C_FILT_FB;
                state_next = S_ANG;
            end
            S_ANG:
            begin
                w_tmp      = clamp(q_round(prod_reg + PROD_W'(acc_reg)), C_LIMIT);
                filt_next  = w_tmp[ANG_W-1:0];
                prior_next = err_reg;
                mul_a      = mul_a_t'({1'b0, av_reg});
                mul_b      = C_ANG_GAIN;
                state_next = S_AERR;
            end
            S_AERR:
            begin
                w_tmp = q_round(prod_reg) + C_ANG_OFFS;
                w_err = -WIDE_W'(filt_reg) - w_tmp;
                // zero error counts as not negative
                if (w_err < 0)
                    w_err = w_err - C_NEG_BIAS;
                else
                    w_err = w_err + C_POS_BIAS;
                w_err      = clamp(w_err, C_LIMIT);
                aerr_next  = w_err[ANG_W-1:0];
                state_next = S_KP;
            end
            S_KP:
            begin
                mul_a      = MUL_A_W'(aerr_reg);
                mul_b      = MUL_B_W'(kp_reg);
                state_next = S_DRIVE;
            end
            S_DRIVE:
            begin
                w_tmp      = clamp(prod_reg[WIDE_W-1:0], C_DRIVE_MAX);
                w_y        = C_DRIVE_MAX - w_tmp;
                // 255 * y + 5, always non-negative
                w_err      = (w_y <<< 8) - w_y + C_ROUND_ADD;
                x_next     = w_err[XNUM_W-1:0];
                state_next = S_DIV;
            end
            S_DIV:
            begin
                mul_a      = mul_a_t'({1'b0, x_reg});
                mul_b      = C_DIV10_RECIP;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // keep the quotient in the product register while stalled
                mul_a = mul_a_t'({1'b0, x_reg});
                mul_b = C_DIV10_RECIP;
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    dac_next       = prod_reg[DIV_SHIFT+DAC_W-1:DIV_SHIFT];
                    ang_out_next   = -filt_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kp_reg        <= '0;
            pv_reg        <= '0;
            av_reg        <= '0;
            tgt_reg       <= '0;
            err_reg       <= '0;
            prior_reg     <= '0;
            filt_reg      <= '0;
            acc_reg       <= '0;
            aerr_reg      <= '0;
            x_reg         <= '0;
            prod_reg      <= '0;
            out_valid_reg <= 1'b0;
            dac_reg       <= '0;
            ang_out_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kp_reg        <= kp_next;
            pv_reg        <= pv_next;
            av_reg        <= av_next;
            tgt_reg       <= tgt_next;
            err_reg       <= err_next;
            prior_reg     <= prior_next;
            filt_reg      <= filt_next;
            acc_reg       <= acc_next;
            aerr_reg      <= aerr_next;
            x_reg         <= x_next;
            prod_reg      <= prod_next;
            out_valid_reg <= out_valid_next;
            dac_reg       <= dac_next;
            ang_out_reg   <= ang_out_next;
        end
    end

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign dac_code     = dac_reg;
    assign angle_target = ang_out_reg;

endmodule

### hdl/bbcc_checker.sv
// Port-level checker for the cascade controller, bound to the top level.
// Depends on bbcc_pkg and ball_beam_cascade_controller_top_defines.svh.
`include "ball_beam_cascade_controller_top_defines.svh"

module bbcc_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_valid,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic        [bbcc_pkg::DAC_W-1:0]    dac_code,
    input logic signed [bbcc_pkg::ANG_W-1:0]    angle_target
);
    import bbcc_pkg::*;

    localparam logic        [DAC_W-1:0] DAC_MAX = 24'd16711680;
    localparam logic signed [ANG_W-1:0] ANG_LIM = 17'sd49807;

    // a stalled result holds its payload
    `BBCC_ASSERT(a_out_hold,
        out_valid && !out_ready |=> out_valid && $stable(dac_code) && $stable(angle_target),
        "result changed while stalled")

    // an accepted request keeps the block busy on the next cycle
    `BBCC_ASSERT(a_busy_after_accept,
        in_valid && in_ready |=> !in_ready, "ready right after a request")

    // the drive code stays within 0..255 in Q16.16 (at most 16711680 raw)
    `BBCC_ASSERT(a_dac_range, out_valid |-> dac_code <= DAC_MAX, "drive code out of range")

    // the angle target stays inside the clamp window
    `BBCC_ASSERT(a_ang_range,
        out_valid |-> angle_target <= ANG_LIM && angle_target >= -ANG_LIM,
        "angle target outside clamp")

    // reset clears any result by the next edge
    `BBCC_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result during reset")

endmodule

bind ball_beam_cascade_controller_top bbcc_checker u_bbcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .dac_code     (dac_code),
    .angle_target (angle_target)
);
